// ===== rtl/core/bse_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths, operation codes, command record and word helpers for the bitmap set engine.
package bse_pkg;

	localparam int unsigned MAP_BITS_DEFAULT = 1024;
	localparam int unsigned INDEX_W          = 11;
	localparam int unsigned WORD_W           = 16;
	localparam int unsigned BPOS_W           = 4;
	localparam int unsigned WIDX_W           = INDEX_W - BPOS_W;
	localparam int unsigned WCNT_W           = WIDX_W + 1;
	localparam int unsigned MAX_SIZE         = (1 << INDEX_W) - 1;
	localparam int unsigned QUEUE_DEPTH      = 2;

	typedef enum logic [3:0] {
		OP_SET        = 4'd0,
		OP_CLEAR      = 4'd1,
		OP_TEST       = 4'd2,
		OP_TEST_SET   = 4'd3,
		OP_TEST_CLEAR = 4'd4,
		OP_CLEAR_ALL  = 4'd5,
		OP_FILL_ALL   = 4'd6,
		OP_ANY        = 4'd7,
		OP_COUNT      = 4'd8,
		OP_SCAN       = 4'd9,
		OP_SNAPSHOT   = 4'd10
	} op_t;

	typedef enum logic [2:0] {
		K_BIT,
		K_CLEAR_ALL,
		K_FILL_ALL,
		K_ANY,
		K_COUNT,
		K_SCAN,
		K_SNAP,
		K_ERROR
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t           kind;
		logic                wr_set;
		logic                wr_clr;
		logic                flag_en;
		logic [WIDX_W-1:0]   widx;
		logic [BPOS_W-1:0]   bpos;
		logic [INDEX_W-1:0]  size;
		logic [WCNT_W-1:0]   words;
	} cmd_t;

	// Mask of the bits in use in the last live word.
	function automatic logic [WORD_W-1:0] tail_mask(input logic [INDEX_W-1:0] size);
		logic [WORD_W-1:0] m;
		m = (WORD_W'(1) << size[BPOS_W-1:0]) - WORD_W'(1);
		if (size[BPOS_W-1:0] == '0) begin
			m = '1;
		end
		return m;
	endfunction

	function automatic logic [4:0] word_pop(input logic [WORD_W-1:0] w);
		logic [WORD_W-1:0] v;
		v = w - ((w >> 1) & 16'h5555);
		v = (v & 16'h3333) + ((v >> 2) & 16'h3333);
		v = (v + (v >> 4)) & 16'h0F0F;
		v = (v + (v >> 8)) & 16'h001F;
		return v[4:0];
	endfunction

	// Position of the lowest set bit; the top position when only it or nothing is set.
	function automatic logic [BPOS_W-1:0] lowest_one(input logic [WORD_W-1:0] w);
		logic [BPOS_W-1:0] b;
		b = BPOS_W'(WORD_W - 1);
		for (int i = WORD_W - 2; i >= 0; i--) begin
			if (w[i]) begin
				b = BPOS_W'(i);
			end
		end
		return b;
	endfunction

endpackage

// ===== rtl/core/bitmap_set_engine.sv =====
`timescale 1ns / 1ps
// Top level of the bitmap set engine: size register, front end and back end.
//
// The engine keeps a set of up to MAP_BITS bits in 16-bit words and runs one
// operation per input transaction: set, clear, test, test-and-set,
// test-and-clear, clear all, fill all, any, population count, scan for the
// next set bit, or snapshot. The logical size comes from the size register,
// which saturates at MAP_BITS and must be written only while the
// engine is idle. A front end range-checks and decodes each transaction and
// pushes it into a two-entry command queue, so the input side keeps taking
// transactions while the back end works, as long as the queue has room; the
// back end executes one command at a time against a single-port word store
// with a registered read and presents results through an output register. A
// single-bit operation reads its word, then modifies and writes it, then
// presents its result; a rejected operation, or a whole-map operation on an
// empty set, goes straight to its result; clear all and fill all write one
// live word per step; any and count read and then use each live word; a scan
// reads and uses each word visited and stops at the first set bit; a snapshot
// reads and uses each live word and gives one result transaction per word,
// the last one flagged. A snapshot of an empty set gives no result at all.
// Each word carries a valid bit that reset clears, so the store reads as all
// zero right after reset with no clearing pass.
module bitmap_set_engine #(
	parameter int unsigned MAP_BITS = bse_pkg::MAP_BITS_DEFAULT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [bse_pkg::INDEX_W-1:0] cfg_wr_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [3:0]                  operation,
	input  logic [bse_pkg::INDEX_W-1:0] bit_index,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        status,
	output logic                        bit_flag,
	output logic [bse_pkg::INDEX_W-1:0] number,
	output logic [bse_pkg::WORD_W-1:0]  data_word,
	output logic                        last
);

	logic [bse_pkg::INDEX_W-1:0] map_size_q;
	logic                        cmd_valid;
	logic                        cmd_ready;
	bse_pkg::cmd_t               cmd;

	// The size register is written directly; there is no read-back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_size_q <= '0;
		end else if (cfg_wr_en) begin
			map_size_q <= cfg_wr_data;
		end
	end

	// Decode and range check; the command carries the saturated size and word count.
	bse_front #(
		.MAP_BITS (MAP_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.bit_index (bit_index),
		.map_size  (map_size_q),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	// Execution against the word store, with the output register.
	bse_back #(
		.MAP_BITS (MAP_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.bit_flag  (bit_flag),
		.number    (number),
		.data_word (data_word),
		.last      (last)
	);

endmodule

// ===== rtl/core/bse_queue.sv =====
`timescale 1ns / 1ps
// Short command queue between the classifier and the execution sequencer.
module bse_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  bse_pkg::cmd_t push_data,
	output logic          pop_valid,
	input  logic          pop_ready,
	output bse_pkg::cmd_t pop_data
);

	localparam int unsigned DEPTH = bse_pkg::QUEUE_DEPTH;
	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	bse_pkg::cmd_t    slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fill_q;
	logic             push;
	logic             pop;

	assign push_ready = (fill_q != CNT_W'(DEPTH));
	assign pop_valid  = (fill_q != '0);
	assign pop_data   = slot_q[rd_ptr_q];
	assign push       = push_valid & push_ready;
	assign pop        = pop_valid & pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + CNT_W'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== rtl/core/bse_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts transactions, range-checks and decodes them into queued commands.
module bse_front #(
	parameter int unsigned MAP_BITS = bse_pkg::MAP_BITS_DEFAULT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [3:0]                  operation,
	input  logic [bse_pkg::INDEX_W-1:0] bit_index,
	input  logic [bse_pkg::INDEX_W-1:0] map_size,
	output logic                        cmd_valid,
	input  logic                        cmd_ready,
	output bse_pkg::cmd_t               cmd
);

	localparam int unsigned IW  = bse_pkg::INDEX_W;
	localparam int unsigned BPW = bse_pkg::BPOS_W;
	localparam int unsigned WW  = bse_pkg::WORD_W;
	localparam int unsigned CAP = (MAP_BITS > bse_pkg::MAX_SIZE) ? bse_pkg::MAX_SIZE : MAP_BITS;

	logic [IW-1:0] size;
	logic [IW:0]   words_sum;
	logic          in_range;
	bse_pkg::cmd_t cls;

	// The register may name more bits than the store holds; the size saturates.
	assign size      = (map_size > IW'(CAP)) ? IW'(CAP) : map_size;
	assign words_sum = (IW + 1)'(size) + (IW + 1)'(WW - 1);
	assign in_range  = (bit_index < size);

	always_comb begin
		cls       = '0;
		cls.kind  = bse_pkg::K_ERROR;
		cls.widx  = bit_index[IW-1:BPW];
		cls.bpos  = bit_index[BPW-1:0];
		cls.size  = size;
		cls.words = words_sum[IW:BPW];
		unique case (bse_pkg::op_t'(operation))
			bse_pkg::OP_SET: begin
				cls.kind   = in_range ? bse_pkg::K_BIT : bse_pkg::K_ERROR;
				cls.wr_set = 1'b1;
			end
			bse_pkg::OP_CLEAR: begin
				cls.kind   = in_range ? bse_pkg::K_BIT : bse_pkg::K_ERROR;
				cls.wr_clr = 1'b1;
			end
			bse_pkg::OP_TEST: begin
				cls.kind    = in_range ? bse_pkg::K_BIT : bse_pkg::K_ERROR;
				cls.flag_en = 1'b1;
			end
			bse_pkg::OP_TEST_SET: begin
				cls.kind    = in_range ? bse_pkg::K_BIT : bse_pkg::K_ERROR;
				cls.wr_set  = 1'b1;
				cls.flag_en = 1'b1;
			end
			bse_pkg::OP_TEST_CLEAR: begin
				cls.kind    = in_range ? bse_pkg::K_BIT : bse_pkg::K_ERROR;
				cls.wr_clr  = 1'b1;
				cls.flag_en = 1'b1;
			end
			bse_pkg::OP_CLEAR_ALL: cls.kind = bse_pkg::K_CLEAR_ALL;
			bse_pkg::OP_FILL_ALL:  cls.kind = bse_pkg::K_FILL_ALL;
			bse_pkg::OP_ANY:       cls.kind = bse_pkg::K_ANY;
			bse_pkg::OP_COUNT:     cls.kind = bse_pkg::K_COUNT;
			// A scan may start exactly at the size and then finds nothing.
			bse_pkg::OP_SCAN:      cls.kind = (bit_index > size) ? bse_pkg::K_ERROR
				: bse_pkg::K_SCAN;
			bse_pkg::OP_SNAPSHOT:  cls.kind = bse_pkg::K_SNAP;
			default:               cls.kind = bse_pkg::K_ERROR;
		endcase
	end

	bse_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (in_valid),
		.push_ready (in_ready),
		.push_data  (cls),
		.pop_valid  (cmd_valid),
		.pop_ready  (cmd_ready),
		.pop_data   (cmd)
	);

endmodule

// ===== rtl/core/bse_back.sv =====
`timescale 1ns / 1ps
// Back end: word store and the sequencer that carries out queued commands.
module bse_back #(
	parameter int unsigned MAP_BITS = bse_pkg::MAP_BITS_DEFAULT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cmd_valid,
	output logic                        cmd_ready,
	input  bse_pkg::cmd_t               cmd,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        status,
	output logic                        bit_flag,
	output logic [bse_pkg::INDEX_W-1:0] number,
	output logic [bse_pkg::WORD_W-1:0]  data_word,
	output logic                        last
);

	localparam int unsigned IW          = bse_pkg::INDEX_W;
	localparam int unsigned WW          = bse_pkg::WORD_W;
	localparam int unsigned XW          = bse_pkg::WIDX_W;
	localparam int unsigned CW          = bse_pkg::WCNT_W;
	localparam int unsigned WORDS_FULL  = (MAP_BITS + WW - 1) / WW;
	localparam int unsigned WORD_LIMIT  = 1 << XW;
	localparam int unsigned STORE_WORDS = (WORDS_FULL > WORD_LIMIT) ? WORD_LIMIT : WORDS_FULL;
	localparam int unsigned AW          = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_BIT,
		S_SWEEP,
		S_WALK_RD,
		S_WALK_USE,
		S_EMIT
	} state_t;

	state_t                 state_q;
	bse_pkg::cmd_t          cmd_q;
	logic [XW-1:0]          addr_q;
	logic [WW-1:0]          store_q [STORE_WORDS];
	logic [STORE_WORDS-1:0] valid_q;
	logic [WW-1:0]          rd_data_q;
	logic                   rd_valid_q;
	logic                   res_status_q;
	logic                   res_flag_q;
	logic [IW-1:0]          res_number_q;
	logic                   out_valid_q;
	logic                   out_status_q;
	logic                   out_flag_q;
	logic [IW-1:0]          out_number_q;
	logic [WW-1:0]          out_data_q;
	logic                   out_last_q;

	logic                   rd_en;
	logic [AW-1:0]          rd_addr;
	logic                   wr_en;
	logic [AW-1:0]          wr_addr;
	logic [WW-1:0]          wr_data;
	logic [WW-1:0]          word_rd;
	logic                   last_word;
	logic [WW-1:0]          live_w;
	logic [WW-1:0]          scan_w;
	logic [WW-1:0]          bit_mask;
	logic [WW-1:0]          bit_new;
	logic                   out_free;
	logic                   out_load;

	assign cmd_ready = (state_q == S_IDLE);
	assign out_free  = !out_valid_q || out_ready;
	// The output register takes a new result in this cycle.
	assign out_load  = out_free && ((state_q == S_EMIT)
		|| ((state_q == S_WALK_USE) && (cmd_q.kind == bse_pkg::K_SNAP)));

	// Words never written since reset read as zero.
	assign word_rd   = rd_valid_q ? rd_data_q : '0;
	assign last_word = ((CW'(addr_q) + CW'(1)) == cmd_q.words);
	assign live_w    = word_rd & (last_word ? bse_pkg::tail_mask(cmd_q.size) : {WW{1'b1}});
	assign scan_w    = (addr_q == cmd_q.widx) ? (live_w & ({WW{1'b1}} << cmd_q.bpos)) : live_w;
	assign bit_mask  = WW'(1) << cmd_q.bpos;
	assign bit_new   = cmd_q.wr_set ? (word_rd | bit_mask) : (word_rd & ~bit_mask);

	assign rd_en   = ((state_q == S_IDLE) && cmd_valid && (cmd.kind == bse_pkg::K_BIT))
		|| (state_q == S_WALK_RD);
	assign rd_addr = (state_q == S_IDLE) ? AW'(cmd.widx) : AW'(addr_q);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = AW'(addr_q);
		wr_data = '0;
		unique case (state_q)
			S_BIT: begin
				wr_en   = cmd_q.wr_set | cmd_q.wr_clr;
				wr_addr = AW'(cmd_q.widx);
				wr_data = bit_new;
			end
			S_SWEEP: begin
				wr_en = 1'b1;
				if (cmd_q.kind == bse_pkg::K_FILL_ALL) begin
					wr_data = last_word ? bse_pkg::tail_mask(cmd_q.size) : {WW{1'b1}};
				end
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= store_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cmd_q        <= '0;
			addr_q       <= '0;
			res_status_q <= 1'b0;
			res_flag_q   <= 1'b0;
			res_number_q <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= 1'b0;
			out_flag_q   <= 1'b0;
			out_number_q <= '0;
			out_data_q   <= '0;
			out_last_q   <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						cmd_q        <= cmd;
						// A scan walks from the word that holds its start bit.
						addr_q       <= (cmd.kind == bse_pkg::K_SCAN) ? cmd.widx : '0;
						res_status_q <= (cmd.kind == bse_pkg::K_ERROR);
						res_flag_q   <= 1'b0;
						res_number_q <= ((cmd.kind == bse_pkg::K_SCAN)
							&& (CW'(cmd.widx) >= cmd.words)) ? cmd.size : '0;
						unique case (cmd.kind)
							bse_pkg::K_BIT: begin
								state_q <= S_BIT;
							end
							bse_pkg::K_CLEAR_ALL, bse_pkg::K_FILL_ALL: begin
								state_q <= (cmd.words == '0) ? S_EMIT : S_SWEEP;
							end
							bse_pkg::K_ANY, bse_pkg::K_COUNT: begin
								state_q <= (cmd.words == '0) ? S_EMIT : S_WALK_RD;
							end
							bse_pkg::K_SCAN: begin
								if (CW'(cmd.widx) >= cmd.words) begin
									state_q <= S_EMIT;
								end else begin
									state_q <= S_WALK_RD;
								end
							end
							bse_pkg::K_SNAP: begin
								state_q <= (cmd.words == '0) ? S_IDLE : S_WALK_RD;
							end
							bse_pkg::K_ERROR: begin
								state_q <= S_EMIT;
							end
						endcase
					end
				end
				S_BIT: begin
					res_flag_q <= cmd_q.flag_en & word_rd[cmd_q.bpos];
					state_q    <= S_EMIT;
				end
				S_SWEEP: begin
					addr_q <= addr_q + XW'(1);
					if (last_word) begin
						state_q <= S_EMIT;
					end
				end
				S_WALK_RD: begin
					state_q <= S_WALK_USE;
				end
				S_WALK_USE: begin
					unique case (cmd_q.kind)
						bse_pkg::K_ANY, bse_pkg::K_COUNT: begin
							if (live_w != '0) begin
								res_flag_q <= (cmd_q.kind == bse_pkg::K_ANY);
							end
							if (cmd_q.kind == bse_pkg::K_COUNT) begin
								res_number_q <= res_number_q + IW'(bse_pkg::word_pop(live_w));
							end
							if (last_word) begin
								state_q <= S_EMIT;
							end else begin
								addr_q  <= addr_q + XW'(1);
								state_q <= S_WALK_RD;
							end
						end
						bse_pkg::K_SCAN: begin
							if (scan_w != '0) begin
								res_number_q <= {addr_q, bse_pkg::lowest_one(scan_w)};
								state_q      <= S_EMIT;
							end else if (last_word) begin
								res_number_q <= cmd_q.size;
								state_q      <= S_EMIT;
							end else begin
								addr_q  <= addr_q + XW'(1);
								state_q <= S_WALK_RD;
							end
						end
						bse_pkg::K_SNAP: begin
							if (out_free) begin
								out_valid_q  <= 1'b1;
								out_status_q <= 1'b0;
								out_flag_q   <= 1'b0;
								out_number_q <= '0;
								out_data_q   <= live_w;
								out_last_q   <= last_word;
								if (last_word) begin
									state_q <= S_IDLE;
								end else begin
									addr_q  <= addr_q + XW'(1);
									state_q <= S_WALK_RD;
								end
							end
						end
						default: begin
							state_q <= S_IDLE;
						end
					endcase
				end
				S_EMIT: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_flag_q   <= res_flag_q;
						out_number_q <= res_number_q;
						out_data_q   <= '0;
						out_last_q   <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign status    = out_status_q;
	assign bit_flag  = out_flag_q;
	assign number    = out_number_q;
	assign data_word = out_data_q;
	assign last      = out_last_q;

endmodule
